@@ hw/rtl/mla_pkg.sv @@
package mla_pkg;

  localparam int MAX_CH    = 8;
  localparam int SAMPLE_W  = 12;
  localparam int LIM_W     = 13;
  localparam int CMP_W     = 14;
  localparam int REG_W     = 52;
  localparam int CFG_IDX_W = 3;
  localparam int COUNT_W   = 4;

  localparam logic [MAX_CH-1:0] ENABLE_RESET = '1;
  localparam logic [REG_W-1:0]  LOW_RESET    = '0;
  localparam logic [REG_W-1:0]  HIGH_RESET   = {4{13'd4096}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE  = 3'd0,
    CFG_LOW_LO  = 3'd1,
    CFG_LOW_HI  = 3'd2,
    CFG_HIGH_LO = 3'd3,
    CFG_HIGH_HI = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic oor;
    logic alert;
    logic high;
    logic low;
  } lane_res_t;

endpackage

@@ hw/rtl/mla_if.sv @@
interface mla_in_if;
  logic        valid;
  logic        ready;
  logic [11:0] sample_ch0;
  logic [11:0] sample_ch1;
  logic [11:0] sample_ch2;
  logic [11:0] sample_ch3;
  logic [11:0] sample_ch4;
  logic [11:0] sample_ch5;
  logic [11:0] sample_ch6;
  logic [11:0] sample_ch7;

  modport source (
    output valid, sample_ch0, sample_ch1, sample_ch2, sample_ch3,
           sample_ch4, sample_ch5, sample_ch6, sample_ch7,
    input  ready
  );
  modport sink (
    input  valid, sample_ch0, sample_ch1, sample_ch2, sample_ch3,
           sample_ch4, sample_ch5, sample_ch6, sample_ch7,
    output ready
  );
endinterface

interface mla_out_if;
  logic       valid;
  logic       ready;
  logic       alert_raised;
  logic [3:0] out_of_range_count;
  logic [7:0] out_of_range_mask;
  logic [7:0] high_alarm_mask;
  logic [7:0] low_alarm_mask;

  modport source (
    output valid, alert_raised, out_of_range_count, out_of_range_mask,
           high_alarm_mask, low_alarm_mask,
    input  ready
  );
  modport sink (
    input  valid, alert_raised, out_of_range_count, out_of_range_mask,
           high_alarm_mask, low_alarm_mask,
    output ready
  );
endinterface

@@ hw/rtl/mla_lane.sv @@
module mla_lane
  import mla_pkg::*;
#(
  parameter int HYSTERESIS = 100,
  parameter int FULL_SCALE = 4096
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                take,
  input  logic                en,
  input  logic [SAMPLE_W-1:0] sample,
  input  logic [LIM_W-1:0]    min_lim,
  input  logic [LIM_W-1:0]    max_lim,
  output lane_res_t           res
);

  localparam logic [CMP_W-1:0] HYST_X = CMP_W'(HYSTERESIS);
  localparam logic [CMP_W-1:0] FS_X   = CMP_W'(FULL_SCALE);

  logic             high_r, high_nxt;
  logic             low_r, low_nxt;
  logic             alert;
  logic [CMP_W-1:0] s_x, mn_x, mx_x, lo_sum;
  logic             above, below, hi_clear, lo_clear;

  assign s_x    = CMP_W'(sample);
  assign mn_x   = CMP_W'(min_lim);
  assign mx_x   = CMP_W'(max_lim);
  assign lo_sum = mn_x + HYST_X;
  assign above  = s_x > mx_x;
  assign below  = s_x < mn_x;

  assign hi_clear = (mx_x > HYST_X) ? ((s_x + HYST_X) < mx_x) : (s_x < mx_x);
  assign lo_clear = (lo_sum < FS_X) ? (s_x > lo_sum) : (s_x > mn_x);

  always_comb begin
    high_nxt = high_r;
    low_nxt  = low_r;
    alert    = 1'b0;
    if (en) begin
      priority if (high_r) begin
        if (hi_clear) high_nxt = 1'b0;
      end else if (low_r) begin
        if (lo_clear) low_nxt = 1'b0;
      end else if (above) begin
        high_nxt = 1'b1;
        alert    = 1'b1;
      end else if (below) begin
        low_nxt = 1'b1;
        alert   = 1'b1;
      end else begin
        alert = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      high_r <= 1'b0;
      low_r  <= 1'b0;
    end else if (take) begin
      high_r <= high_nxt;
      low_r  <= low_nxt;
    end
  end

  assign res.oor   = en & (above | below);
  assign res.alert = alert;
  assign res.high  = high_nxt;
  assign res.low   = low_nxt;

endmodule

@@ hw/rtl/mla_merge.sv @@
module mla_merge
  import mla_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       take,
  input  lane_res_t  lane_res [MAX_CH],
  output logic       room,
  mla_out_if.source  out_word
);

  logic               valid_r;
  logic               alert_r, alert_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [MAX_CH-1:0]  oor_r, oor_nxt;
  logic [MAX_CH-1:0]  high_r, high_nxt;
  logic [MAX_CH-1:0]  low_r, low_nxt;

  always_comb begin
    alert_nxt = 1'b0;
    count_nxt = '0;
    for (int i = 0; i < MAX_CH; i++) begin
      alert_nxt   = alert_nxt | lane_res[i].alert;
      count_nxt   = count_nxt + COUNT_W'(lane_res[i].oor);
      oor_nxt[i]  = lane_res[i].oor;
      high_nxt[i] = lane_res[i].high;
      low_nxt[i]  = lane_res[i].low;
    end
  end

  assign room = !valid_r || out_word.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (room) begin
      valid_r <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      alert_r <= alert_nxt;
      count_r <= count_nxt;
      oor_r   <= oor_nxt;
      high_r  <= high_nxt;
      low_r   <= low_nxt;
    end
  end

  assign out_word.valid              = valid_r;
  assign out_word.alert_raised       = alert_r;
  assign out_word.out_of_range_count = count_r;
  assign out_word.out_of_range_mask  = oor_r;
  assign out_word.high_alarm_mask    = high_r;
  assign out_word.low_alarm_mask     = low_r;

endmodule

@@ hw/rtl/multichannel_limit_alarm_core.sv @@
// Window comparator with hysteresis over eight 12-bit converter channels. Each
// input word is one scan; every enabled channel is checked against its 13-bit
// lower and upper limits, out-of-range channels are counted and masked, and a
// per-channel high or low alarm is latched on a limit crossing and released with
// HYSTERESIS counts of margin. One result word per scan. A scan's result is
// registered in the cycle after acceptance; one lane per channel does the compare
// and alarm update in parallel and a merge stage counts, so a new scan is
// accepted every cycle while the output is free or being taken. Channels at or
// above CHANNELS read as disabled. Write limits and enables only while idle.
module multichannel_limit_alarm_core
  import mla_pkg::*;
#(
  parameter int CHANNELS   = 8,
  parameter int HYSTERESIS = 100,
  parameter int FULL_SCALE = 4096
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_wdata,
  mla_in_if.sink               in_word,
  mla_out_if.source            out_word
);

  logic [MAX_CH-1:0]   enable_r;
  logic [REG_W-1:0]    low_lo_r, low_hi_r, high_lo_r, high_hi_r;
  logic [2*REG_W-1:0]  low_all, high_all;
  logic [SAMPLE_W-1:0] samples [MAX_CH];
  lane_res_t           lane_res [MAX_CH];
  logic                room;
  logic                take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r  <= ENABLE_RESET;
      low_lo_r  <= LOW_RESET;
      low_hi_r  <= LOW_RESET;
      high_lo_r <= HIGH_RESET;
      high_hi_r <= HIGH_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_ENABLE:  enable_r  <= cfg_wdata[MAX_CH-1:0];
        CFG_LOW_LO:  low_lo_r  <= cfg_wdata;
        CFG_LOW_HI:  low_hi_r  <= cfg_wdata;
        CFG_HIGH_LO: high_lo_r <= cfg_wdata;
        CFG_HIGH_HI: high_hi_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign low_all  = {low_hi_r, low_lo_r};
  assign high_all = {high_hi_r, high_lo_r};

  assign samples[0] = in_word.sample_ch0;
  assign samples[1] = in_word.sample_ch1;
  assign samples[2] = in_word.sample_ch2;
  assign samples[3] = in_word.sample_ch3;
  assign samples[4] = in_word.sample_ch4;
  assign samples[5] = in_word.sample_ch5;
  assign samples[6] = in_word.sample_ch6;
  assign samples[7] = in_word.sample_ch7;

  assign in_word.ready = room;
  assign take          = in_word.valid && room;

  for (genvar g = 0; g < MAX_CH; g++) begin : g_lane
    if (g < CHANNELS) begin : g_on
      mla_lane #(
        .HYSTERESIS (HYSTERESIS),
        .FULL_SCALE (FULL_SCALE)
      ) u_lane (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (take),
        .en      (enable_r[g]),
        .sample  (samples[g]),
        .min_lim (low_all[LIM_W*g +: LIM_W]),
        .max_lim (high_all[LIM_W*g +: LIM_W]),
        .res     (lane_res[g])
      );
    end else begin : g_off
      assign lane_res[g] = '0;
    end
  end

  mla_merge u_merge (
    .clk      (clk),
    .rst_n    (rst_n),
    .take     (take),
    .lane_res (lane_res),
    .room     (room),
    .out_word (out_word)
  );

endmodule
